[hdl/urld_pkg.sv]
package urld_pkg;

  localparam int BPP_W      = 4;
  localparam int WIDTH_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD   = 2'd2;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 4'd3;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1024;
  localparam logic [7:0]         PAD_RESET   = 8'hFF;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_BUSY     = 3'd1,
    ST_VALID    = 3'd2,
    ST_NONE     = 3'd3,
    ST_ERROR    = 3'd4
  } status_e;

  typedef struct packed {
    logic [BPP_W-1:0] bpp;
    logic [7:0]       pad;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       eol;
    logic       last;
  } result_t;

endpackage

[hdl/urf_raster_line_decoder.sv]
// Decoder for URF/PWG raster line compression, one compressed byte per pushed word.
// Each line is rebuilt in an on-chip line store of LINE_BYTES bytes, then read back
// one byte per pull word, once per line copy. Push words that open a line, pick a
// code or carry a pixel or literal byte are answered from the idle state, as are
// refused words and pulls answered without a store read; a pull that returns a byte
// goes through a read state, as the line store has a registered read port. A pad
// code fills the rest of the line and the last byte of a repeated pixel fills the
// remaining copies through the single store write port one byte per cycle; input
// is stalled meanwhile. Store contents are not cleared at reset. Configuration may
// change only while the block is idle.
module urf_raster_line_decoder #(
  parameter int LINE_BYTES      = 32768,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [urld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [7:0]                      out_byte_o,
  output logic                            end_of_line_o,
  output logic                            last_copy_o
);

  import urld_pkg::*;

  localparam int PW = $clog2(LINE_BYTES + 2048);
  localparam int AW = $clog2(LINE_BYTES);

  cfg_t          cfg;
  logic [PW-1:0] line_bytes;
  logic          idle;
  logic          take;
  logic          out_free;
  logic          res_valid;
  result_t       res;
  result_t       res_q;
  logic          out_valid_q, out_valid_d;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(idle && out_free);
  assign take       = in_valid_i && !in_stall_o;

  urld_cfg #(
    .LINE_BYTES      (LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cfg_o        (cfg),
    .line_bytes_o (line_bytes)
  );

  urld_engine #(
    .LINE_BYTES      (LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .op_i         (operation_i),
    .byte_i       (data_byte_i),
    .cfg_i        (cfg),
    .line_bytes_i (line_bytes),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  urld_line_store #(
    .LINE_BYTES (LINE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // hold the result until taken
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign out_byte_o    = res_q.data;
  assign end_of_line_o = res_q.eol;
  assign last_copy_o   = res_q.last;

endmodule

[hdl/urld_line_store.sv]
module urld_line_store #(
  parameter int LINE_BYTES = 32768,
  localparam int AW = $clog2(LINE_BYTES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] store_q [LINE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/urld_cfg.sv]
module urld_cfg #(
  parameter int LINE_BYTES      = 32768,
  parameter int MAX_PIXEL_BYTES = 8,
  localparam int PW = $clog2(LINE_BYTES + 2048)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urld_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output urld_pkg::cfg_t                 cfg_o,
  output logic [PW-1:0]                  line_bytes_o
);

  import urld_pkg::*;

  localparam int PROD_W = WIDTH_W + BPP_W;
  localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);
  localparam int RST_BPP = (int'(BPP_RESET) > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES
                                                               : int'(BPP_RESET);
  localparam int RST_PROD = int'(WIDTH_RESET) * RST_BPP;
  localparam int RST_LB = (RST_PROD > LINE_BYTES) ? LINE_BYTES : RST_PROD;

  logic [BPP_W-1:0]   bpp_q, bpp_d, bpp_wr;
  logic [WIDTH_W-1:0] width_q, width_d, width_wr;
  logic [7:0]         pad_q, pad_d;
  logic [PW-1:0]      lb_q, lb_d;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    bpp_wr = cfg_wdata_i[BPP_W-1:0];
    if (bpp_wr == '0) begin
      bpp_wr = BPP_W'(1);
    end else if (bpp_wr > MAX_BPP) begin
      bpp_wr = MAX_BPP;
    end
    width_wr = cfg_wdata_i[WIDTH_W-1:0];
    if (width_wr == '0) begin
      width_wr = WIDTH_W'(1);
    end

    bpp_d   = bpp_q;
    width_d = width_q;
    pad_d   = pad_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:   bpp_d = bpp_wr;
        CFG_WIDTH: width_d = width_wr;
        CFG_PAD:   pad_d = cfg_wdata_i[7:0];
        default:   ;
      endcase
    end

    prod = PROD_W'(width_d) * PROD_W'(bpp_d);
    if (prod > PROD_W'(LINE_BYTES)) begin
      lb_d = PW'(LINE_BYTES);
    end else begin
      lb_d = PW'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_W'(RST_BPP);
      width_q <= WIDTH_RESET;
      pad_q   <= PAD_RESET;
      lb_q    <= PW'(RST_LB);
    end else begin
      bpp_q   <= bpp_d;
      width_q <= width_d;
      pad_q   <= pad_d;
      lb_q    <= lb_d;
    end
  end

  assign cfg_o.bpp    = bpp_q;
  assign cfg_o.pad    = pad_q;
  assign line_bytes_o = lb_q;

endmodule

[hdl/urld_engine.sv]
module urld_engine #(
  parameter int LINE_BYTES      = 32768,
  parameter int MAX_PIXEL_BYTES = 8,
  localparam int PW = $clog2(LINE_BYTES + 2048),
  localparam int AW = $clog2(LINE_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              op_i,
  input  logic [7:0]        byte_i,
  input  urld_pkg::cfg_t    cfg_i,
  input  logic [PW-1:0]     line_bytes_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output urld_pkg::result_t res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [7:0]        mem_rdata_i
);

  import urld_pkg::*;

  localparam int IW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int XW    = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int RUN_W = $clog2(128 * MAX_PIXEL_BYTES + 1);
  localparam int MUL_W = 9 + BPP_W;
  localparam logic [7:0] CODE_PAD = 8'h80;
  localparam logic [8:0] LIT_BASE = 9'd257;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PAD, S_COPY} state_e;
  typedef enum logic [1:0] {PH_LINE_REP, PH_CODE, PH_PIXEL, PH_LITERAL} phase_e;

  state_e           st_q, st_d;
  phase_e           ph_q, ph_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [8:0]       copies_q, copies_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [7:0]       rep_q, rep_d;
  logic [XW-1:0]    idx_q, idx_d, idx_nx;
  logic             err_q, err_d;
  logic [PW-1:0]    cp_addr_q, cp_addr_d;
  logic [RUN_W-1:0] cp_left_q, cp_left_d;
  logic [IW-1:0]    cp_j_q, cp_j_d;
  logic             rd_ok_q, rd_ok_d;
  logic             rd_eol_q, rd_eol_d;
  logic             rd_last_q, rd_last_d;
  logic [7:0]       pix_q [MAX_PIXEL_BYTES];

  logic [BPP_W-1:0] bpp;
  logic             emitting;
  logic [8:0]       mul_a;
  logic [MUL_W-1:0] prod;
  logic [PW:0]      run_end;
  logic [PW:0]      pos_inc;
  logic             over;
  logic             pix_we;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  assign bpp      = cfg_i.bpp;
  assign emitting = (ph_q == PH_LINE_REP) && (copies_q != '0);
  assign idle_o   = (st_q == S_IDLE);

  always_comb begin
    if (ph_q == PH_PIXEL) begin
      mul_a = 9'(rep_q);
    end else if (byte_i < CODE_PAD) begin
      mul_a = 9'(byte_i) + 9'd1;
    end else begin
      mul_a = LIT_BASE - 9'(byte_i);
    end
    prod    = MUL_W'(mul_a) * MUL_W'(bpp);
    run_end = (PW+1)'(pos_q) + (PW+1)'(prod);
    over    = run_end > (PW+1)'(line_bytes_i);
    pos_inc = (PW+1)'(pos_q) + (PW+1)'(1);
    idx_nx  = idx_q + XW'(1);
  end

  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    pos_d     = pos_q;
    copies_d  = copies_q;
    run_d     = run_q;
    rep_d     = rep_q;
    idx_d     = idx_q;
    err_d     = err_q;
    cp_addr_d = cp_addr_q;
    cp_left_d = cp_left_q;
    cp_j_d    = cp_j_q;
    rd_ok_d   = rd_ok_q;
    rd_eol_d  = rd_eol_q;
    rd_last_d = rd_last_q;
    pix_we    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = byte_i;
    mem_re_o  = 1'b0;
    res_valid_o   = 1'b0;
    res_o.status  = ST_ACCEPTED;
    res_o.data    = '0;
    res_o.eol     = 1'b0;
    res_o.last    = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (take_i) begin
          res_valid_o = 1'b1;
          if (err_q) begin
            res_o.status = ST_ERROR;
          end else if (op_i == OP_PUSH) begin
            if (emitting) begin
              res_o.status = ST_BUSY;
            end else begin
              case (ph_q)
                PH_LINE_REP: begin
                  copies_d = 9'(byte_i) + 9'd1;
                  pos_d    = '0;
                  ph_d     = PH_CODE;
                end
                PH_CODE: begin
                  if (byte_i == CODE_PAD) begin
                    st_d = S_PAD;
                  end else if (over) begin
                    err_d        = 1'b1;
                    res_o.status = ST_ERROR;
                  end else if (byte_i < CODE_PAD) begin
                    rep_d = byte_i + 8'd1;
                    idx_d = '0;
                    ph_d  = PH_PIXEL;
                  end else begin
                    run_d = RUN_W'(prod);
                    ph_d  = PH_LITERAL;
                  end
                end
                PH_PIXEL: begin
                  wr_en   = 1'b1;
                  wr_addr = pos_q + PW'(idx_q);
                  pix_we  = 1'b1;
                  if ((BPP_W+1)'(idx_nx) >= (BPP_W+1)'(bpp)) begin
                    pos_d     = PW'(run_end);
                    cp_addr_d = pos_q + PW'(bpp);
                    cp_left_d = RUN_W'(prod) - RUN_W'(bpp);
                    cp_j_d    = '0;
                    idx_d     = '0;
                    rep_d     = '0;
                    st_d      = S_COPY;
                  end else begin
                    idx_d = idx_nx;
                  end
                end
                PH_LITERAL: begin
                  wr_en = 1'b1;
                  pos_d = PW'(pos_inc);
                  if (run_q != '0) begin
                    run_d = run_q - RUN_W'(1);
                  end
                  if (run_q <= RUN_W'(1)) begin
                    if (pos_inc >= (PW+1)'(line_bytes_i)) begin
                      pos_d = '0;
                      ph_d  = PH_LINE_REP;
                    end else begin
                      ph_d = PH_CODE;
                    end
                  end
                end
                default: ;
              endcase
            end
          end else if (!emitting) begin
            res_o.status = ST_NONE;
          end else begin
            res_valid_o = 1'b0;
            mem_re_o    = 1'b1;
            rd_ok_d     = pos_q < PW'(LINE_BYTES);
            rd_last_d   = (copies_q == 9'd1);
            rd_eol_d    = 1'b0;
            pos_d       = PW'(pos_inc);
            if (pos_inc >= (PW+1)'(line_bytes_i)) begin
              rd_eol_d = 1'b1;
              pos_d    = '0;
              copies_d = copies_q - 9'd1;
            end
            st_d = S_READ;
          end
        end
      end
      S_READ: begin
        res_valid_o  = 1'b1;
        res_o.status = ST_VALID;
        res_o.data   = rd_ok_q ? mem_rdata_i : 8'd0;
        res_o.eol    = rd_eol_q;
        res_o.last   = rd_last_q;
        st_d         = S_IDLE;
      end
      S_PAD: begin
        if (pos_q < line_bytes_i) begin
          wr_en   = 1'b1;
          wr_data = cfg_i.pad;
          pos_d   = PW'(pos_inc);
        end else begin
          pos_d = '0;
          ph_d  = PH_LINE_REP;
          st_d  = S_IDLE;
        end
      end
      S_COPY: begin
        if (cp_left_q == '0) begin
          if (pos_q >= line_bytes_i) begin
            pos_d = '0;
            ph_d  = PH_LINE_REP;
          end else begin
            ph_d = PH_CODE;
          end
          st_d = S_IDLE;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = cp_addr_q;
          wr_data   = pix_q[cp_j_q];
          cp_addr_d = cp_addr_q + PW'(1);
          cp_left_d = cp_left_q - RUN_W'(1);
          if ((BPP_W+1)'(cp_j_q) + (BPP_W+1)'(1) >= (BPP_W+1)'(bpp)) begin
            cp_j_d = '0;
          end else begin
            cp_j_d = cp_j_q + IW'(1);
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign mem_we_o    = wr_en && (wr_addr < PW'(LINE_BYTES));
  assign mem_waddr_o = wr_addr[AW-1:0];
  assign mem_wdata_o = wr_data;
  assign mem_raddr_o = pos_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ph_q      <= PH_LINE_REP;
      pos_q     <= '0;
      copies_q  <= '0;
      run_q     <= '0;
      rep_q     <= '0;
      idx_q     <= '0;
      err_q     <= 1'b0;
      cp_addr_q <= '0;
      cp_left_q <= '0;
      cp_j_q    <= '0;
      rd_ok_q   <= 1'b0;
      rd_eol_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      ph_q      <= ph_d;
      pos_q     <= pos_d;
      copies_q  <= copies_d;
      run_q     <= run_d;
      rep_q     <= rep_d;
      idx_q     <= idx_d;
      err_q     <= err_d;
      cp_addr_q <= cp_addr_d;
      cp_left_q <= cp_left_d;
      cp_j_q    <= cp_j_d;
      rd_ok_q   <= rd_ok_d;
      rd_eol_q  <= rd_eol_d;
      rd_last_q <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_q[idx_q[IW-1:0]] <= byte_i;
    end
  end

  a_take_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> (st_q == S_IDLE))
    else $error("word taken while engine busy");

  a_read_follows_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ) |-> $past(take_i && (op_i == OP_PULL) && !err_q))
    else $error("store read result without a pull");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag cleared");

  a_pixel_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < XW'(MAX_PIXEL_BYTES))
    else $error("pixel byte index out of range");

endmodule

[test/tb_urf_raster_line_decoder.sv]
module tb_urf_raster_line_decoder;
  import urld_pkg::*;

  localparam int LINE_BYTES       = 32768;
  localparam int PIXEL_BYTES_MAX  = 8;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [7:0] PAD_CODE = 8'h80;
  localparam int LITERAL_BASE     = 257;

  typedef enum int {DEC_REPEAT, DEC_CODE, DEC_PIXEL, DEC_LITERAL} dec_phase_e;

  class line_decoder_board;
    logic [BPP_W-1:0]   bpp_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [7:0]         pad_reg;
    dec_phase_e         phase;
    int                 fill_pos;
    int                 copies_left;
    int                 run_left;
    int                 repeat_left;
    int                 pixel_idx;
    bit                 sticky_error;
    logic [7:0]         line_mem [LINE_BYTES];
    result_t            expected_words [$];
    int                 errors;

    function new();
      bpp_reg      = BPP_RESET;
      width_reg    = WIDTH_RESET;
      pad_reg      = PAD_RESET;
      phase        = DEC_REPEAT;
      fill_pos     = 0;
      copies_left  = 0;
      run_left     = 0;
      repeat_left  = 0;
      pixel_idx    = 0;
      sticky_error = 1'b0;
      errors       = 0;
    endfunction

    function int pixel_bytes();
      int b;
      b = bpp_reg;
      if (b == 0) b = 1;
      if (b > PIXEL_BYTES_MAX) b = PIXEL_BYTES_MAX;
      return b;
    endfunction

    function int line_bytes();
      int n;
      n = (width_reg == 0 ? 1 : int'(width_reg)) * pixel_bytes();
      return n > LINE_BYTES ? LINE_BYTES : n;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BPP:   bpp_reg = val[BPP_W-1:0];
        CFG_WIDTH: width_reg = val[WIDTH_W-1:0];
        CFG_PAD:   pad_reg = val[7:0];
        default: ;
      endcase
    endfunction

    function bit emitting();
      return phase == DEC_REPEAT && copies_left > 0;
    endfunction

    function bit line_closed();
      return phase == DEC_REPEAT && copies_left == 0;
    endfunction

    function void store_put(int at, logic [7:0] v);
      if (at < LINE_BYTES) line_mem[at] = v;
    endfunction

    function logic [7:0] store_get(int at);
      return (at < LINE_BYTES) ? line_mem[at] : 8'h00;
    endfunction

    function void close_line();
      fill_pos = 0;
      phase = DEC_REPEAT;
    endfunction

    function status_e decode_push(logic [7:0] b);
      int bpp, wb;
      bpp = pixel_bytes();
      wb = line_bytes();
      case (phase)
        DEC_REPEAT: begin
          copies_left = b + 1;
          fill_pos = 0;
          phase = DEC_CODE;
        end
        DEC_CODE: begin
          if (b == PAD_CODE) begin
            for (int i = fill_pos; i < wb; i++) store_put(i, pad_reg);
            close_line();
          end else if (b < PAD_CODE) begin
            repeat_left = b + 1;
            if (fill_pos + repeat_left * bpp > wb) begin
              sticky_error = 1'b1;
              return ST_ERROR;
            end
            pixel_idx = 0;
            phase = DEC_PIXEL;
          end else begin
            run_left = (LITERAL_BASE - b) * bpp;
            if (fill_pos + run_left > wb) begin
              sticky_error = 1'b1;
              return ST_ERROR;
            end
            phase = DEC_LITERAL;
          end
        end
        DEC_PIXEL: begin
          store_put(fill_pos + pixel_idx, b);
          pixel_idx++;
          if (pixel_idx >= bpp) begin
            for (int k = 1; k < repeat_left; k++)
              for (int j = 0; j < bpp; j++)
                store_put(fill_pos + k * bpp + j, store_get(fill_pos + j));
            fill_pos += repeat_left * bpp;
            repeat_left = 0;
            pixel_idx = 0;
            if (fill_pos >= wb) close_line();
            else phase = DEC_CODE;
          end
        end
        default: begin
          store_put(fill_pos, b);
          fill_pos++;
          if (run_left > 0) run_left--;
          if (run_left == 0) begin
            if (fill_pos >= wb) close_line();
            else phase = DEC_CODE;
          end
        end
      endcase
      return ST_ACCEPTED;
    endfunction

    function status_e take_word(op_e op, logic [7:0] b);
      result_t r;
      r = '{status: ST_NONE, data: 8'h00, eol: 1'b0, last: 1'b0};
      if (sticky_error) begin
        r.status = ST_ERROR;
      end else if (op == OP_PUSH) begin
        r.status = emitting() ? ST_BUSY : decode_push(b);
      end else if (!emitting()) begin
        r.status = ST_NONE;
      end else begin
        r.status = ST_VALID;
        r.data = store_get(fill_pos);
        r.last = (copies_left == 1);
        fill_pos++;
        if (fill_pos >= line_bytes()) begin
          r.eol = 1'b1;
          fill_pos = 0;
          copies_left--;
        end
      end
      expected_words.push_back(r);
      return r.status;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= SHOWN_MISMATCHES) $display("ERROR: %s", msg);
    endfunction

    function void match_result(logic [2:0] st, logic [7:0] d, logic eol, logic last);
      result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word: status %0d byte %02h eol %0b last %0b",
                         st, d, eol, last));
        return;
      end
      want = expected_words.pop_front();
      if (st !== want.status || d !== want.data || eol !== want.eol || last !== want.last)
        report($sformatf({"expected status %0d byte %02h eol %0b last %0b, ",
                          "got status %0d byte %02h eol %0b last %0b"},
                         want.status, want.data, want.eol, want.last, st, d, eol, last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [2:0]            status_o;
  logic [7:0]            out_byte_o;
  logic                  end_of_line_o;
  logic                  last_copy_o;

  bit         got_valid = 1'b0;
  logic [2:0] got_status;
  logic [7:0] got_byte;
  logic       got_eol;
  logic       got_last;

  int send_idle;
  int stall_pct;
  int cycle_count;

  line_decoder_board board = new();

  urf_raster_line_decoder #(
    .LINE_BYTES      (LINE_BYTES),
    .MAX_PIXEL_BYTES (PIXEL_BYTES_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_byte_o    (out_byte_o),
    .end_of_line_o (end_of_line_o),
    .last_copy_o   (last_copy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    got_valid  <= rst_ni && out_valid_o && !out_stall_i;
    got_status <= status_o;
    got_byte   <= out_byte_o;
    got_eol    <= end_of_line_o;
    got_last   <= last_copy_o;
  end

  always @(negedge clk_i) begin
    if (got_valid) board.match_result(got_status, got_byte, got_eol, got_last);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("urf_raster_line_decoder verification failed");
    $finish;
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic send_word(input op_e op, input logic [7:0] b, output status_e st);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    st = board.take_word(op, b);
  endtask

  task automatic push_word(input logic [7:0] b);
    status_e st;
    send_word(OP_PUSH, b, st);
  endtask

  task automatic pull_word();
    status_e st;
    send_word(OP_PULL, 8'($urandom), st);
  endtask

  task automatic drain_line();
    while (board.emitting()) pull_word();
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) @(negedge clk_i);
    repeat (board.line_bytes() + 8) @(negedge clk_i);
  endtask

  function automatic void pick_word(input bit closing, output op_e op,
                                    output logic [7:0] b);
    int rem, room, n;
    op = OP_PUSH;
    b = 8'($urandom);
    if (board.emitting()) begin
      if ($urandom_range(0, 9) != 0) op = OP_PULL;
    end else if (!closing && $urandom_range(0, 9) == 0) begin
      op = OP_PULL;
    end else begin
      case (board.phase)
        DEC_REPEAT: begin
          if (!(board.line_bytes() <= 2 && $urandom_range(0, 3) == 0))
            b = 8'($urandom_range(0, 3));
        end
        DEC_CODE: begin
          rem = board.line_bytes() - board.fill_pos;
          room = rem / board.pixel_bytes();
          if (closing || room == 0 || $urandom_range(0, 6) == 0) begin
            b = PAD_CODE;
          end else begin
            n = $urandom_range(1, room > 128 ? 128 : room);
            if (n < 2 || $urandom_range(0, 1) == 0) b = 8'(n - 1);
            else b = 8'(LITERAL_BASE - n);
          end
        end
        default: ;
      endcase
    end
  endfunction

  task automatic run_phase(input int goal, input int bpp, input int width, input int pad);
    int counted;
    op_e op;
    logic [7:0] b;
    status_e st;
    settle();
    write_cfg(CFG_BPP, bpp);
    write_cfg(CFG_WIDTH, width);
    write_cfg(CFG_PAD, pad);
    counted = 0;
    while (counted < goal || !board.line_closed()) begin
      pick_word(counted >= goal, op, b);
      send_word(op, b, st);
      if (st == ST_ACCEPTED || st == ST_VALID) counted++;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BPP;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_PUSH;
    data_byte_i = 8'h00;
    send_idle   = 33;
    stall_pct   = 51;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(CFG_BPP, 1);
    write_cfg(CFG_WIDTH, 4);
    write_cfg(CFG_PAD, 8'hA5);
    pull_word();
    push_word(8'h01);
    push_word(8'h00);
    push_word(8'h00);
    push_word(8'hFF);
    push_word(8'h12);
    push_word(8'hFF);
    push_word(PAD_CODE);
    push_word(8'h33);
    drain_line();
    push_word(8'h00);
    push_word(8'hFD);
    push_word(8'hFF);
    push_word(8'h00);
    push_word(8'h80);
    push_word(8'h7F);
    drain_line();
    push_word(8'h00);
    push_word(8'h03);
    push_word(8'hC3);
    drain_line();

    // hold a line part way, then shrink the width below the position
    settle();
    write_cfg(CFG_WIDTH, 8);
    push_word(8'h00);
    push_word(8'hFD);
    repeat (4) push_word(8'($urandom));
    settle();
    write_cfg(CFG_WIDTH, 3);
    push_word(PAD_CODE);
    drain_line();

    run_phase(30, 0, 0, 8'h00);
    run_phase(30, $urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 255));

    settle();
    send_idle = 51;
    stall_pct = 33;
    run_phase(30, 15, 2, 8'hFF);
    run_phase(30, $urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 255));

    settle();
    send_idle = 0;
    stall_pct = 0;
    run_phase(30, $urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 255));
    run_phase(30, $urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 255));

    // overrun the line, then confirm the error sticks
    push_word(8'($urandom_range(0, 3)));
    push_word($urandom_range(0, 1) ? 8'h7F : 8'h81);
    push_word(8'($urandom));
    pull_word();

    settle();
    if (board.errors == 0) begin
      $display("urf_raster_line_decoder verification clean");
    end else begin
      $display("urf_raster_line_decoder verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/urld_pkg.sv
hdl/urld_line_store.sv
hdl/urld_cfg.sv
hdl/urld_engine.sv
hdl/urf_raster_line_decoder.sv
test/tb_urf_raster_line_decoder.sv
